[rtl/core/bmhq_pkg.sv]
package bmhq_pkg;

   localparam int KEY_W     = 32;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int ENTRIES_W = 11;

   typedef enum logic [OP_W-1:0] {
      OP_OFFER = 2'd0,
      OP_POLL  = 2'd1,
      OP_PEEK  = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP,
      S_PEEK,
      S_POLL_ROOT,
      S_POLL_LAST,
      S_DN_R,
      S_DN_CMP,
      S_DN_FIN,
      S_DONE
   } state_type;

endpackage

[rtl/core/binary_min_heap_queue.sv]
// Binary min-heap priority queue of signed 32-bit keys held in one DEPTH-entry
// synchronous memory (one write and one registered read per cycle). A request
// carries an op: offer inserts req_key_in, poll removes and returns the minimum,
// peek returns the minimum and leaves the heap alone; an unused op code only
// reports the current count. Every request produces exactly one response with
// the key (zero unless a poll or peek succeeds), a status (ok, empty, full) and
// the number of keys held afterwards, masked to 11 bits. An offer to a full
// heap is dropped. The block works on one request at a time. An offer climbs
// from the new slot towards the root while the key beats its parent. A poll
// reads the root, then the last key, and sinks that key level by level; each
// level needs two reads (left and right child) through the single read port.
// The next request is accepted at the end of the cycle in which the response
// appears. One response register holds a finished result, so the next request
// may start while the previous response is still stalled; a result that finds
// the register still occupied waits for it. No clearing pass after reset: only
// held entries are ever read.
module binary_min_heap_queue
   import bmhq_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [OP_W-1:0]             req_op,
   input  logic signed [KEY_W-1:0]     req_key_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [KEY_W-1:0]     rsp_key_out,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [ENTRIES_W-1:0]        rsp_entries
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = CW + 1;

   // heap storage, registered read
   logic signed [KEY_W-1:0] heap_mem [DEPTH];
   logic signed [KEY_W-1:0] rd_data_ff;
   logic [AW-1:0]           rd_addr;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic signed [KEY_W-1:0] wr_data;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           last_ff, last_in;
   logic [AW-1:0]           slot_ff, slot_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic signed [KEY_W-1:0] left_ff, left_in;
   logic signed [KEY_W-1:0] res_key_ff, res_key_in;
   status_type              res_status_ff, res_status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [KEY_W-1:0] rsp_key_ff;
   status_type              rsp_status_ff;
   logic [ENTRIES_W-1:0]    rsp_entries_ff;
   logic                    rsp_load;

   // sift-down helpers
   logic [CW-1:0]           half;
   logic [AW:0]             lchild_w;
   logic [AW:0]             rchild_w;
   logic                    right_ok;
   logic                    take_right;
   logic signed [KEY_W-1:0] pick_key;
   logic [AW-1:0]           pick_idx;
   logic [AW:0]             pick_lchild_w;

   function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] s);
      logic [AW-1:0] p;
      p = (s - 1'b1) >> 1;
      if (s == '0) begin
         p = '0;
      end
      return p;
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= heap_mem[rd_addr];
   end

   assign half          = last_ff >> 1;
   assign lchild_w      = {slot_ff, 1'b1};
   assign rchild_w      = lchild_w + 1'b1;
   assign right_ok      = XW'(rchild_w) < XW'(last_ff);
   // on a tie keep the left child
   assign take_right    = right_ok && (rd_data_ff < left_ff);
   assign pick_key      = take_right ? rd_data_ff : left_ff;
   assign pick_idx      = take_right ? rchild_w[AW-1:0] : lchild_w[AW-1:0];
   assign pick_lchild_w = {pick_idx, 1'b1};

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      slot_in       = slot_ff;
      key_in        = key_ff;
      left_in       = left_ff;
      res_key_in    = res_key_ff;
      res_status_in = res_status_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = slot_ff;
      wr_data       = key_ff;
      rsp_load      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in        = req_key_in;
               res_key_in    = '0;
               res_status_in = ST_OK;
               slot_in       = count_ff[AW-1:0];
               last_in       = count_ff - 1'b1;
               case (req_op)
                  OP_OFFER: begin
                     if (count_ff >= CW'(DEPTH)) begin
                        res_status_in = ST_FULL;
                        state_in      = S_DONE;
                     end else begin
                        // fetch the parent of the new slot
                        rd_addr  = parent_of(count_ff[AW-1:0]);
                        state_in = S_UP;
                     end
                  end
                  OP_POLL: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_POLL_ROOT;
                     end
                  end
                  OP_PEEK: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_PEEK;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_UP: begin
            if ((slot_ff == '0) || !(key_ff < rd_data_ff)) begin
               // settle the new key here
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = S_DONE;
            end else begin
               // move the parent down, climb one level
               wr_en   = 1'b1;
               wr_data = rd_data_ff;
               slot_in = parent_of(slot_ff);
               rd_addr = parent_of(parent_of(slot_ff));
            end
         end

         S_PEEK: begin
            res_key_in = rd_data_ff;
            state_in   = S_DONE;
         end

         S_POLL_ROOT: begin
            res_key_in = rd_data_ff;
            count_in   = last_ff;
            rd_addr    = last_ff[AW-1:0];
            state_in   = (last_ff == '0) ? S_DONE : S_POLL_LAST;
         end

         S_POLL_LAST: begin
            key_in  = rd_data_ff;
            slot_in = '0;
            wr_addr = '0;
            wr_data = rd_data_ff;
            if (half == '0) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr  = AW'(1);
               state_in = S_DN_R;
            end
         end

         S_DN_R: begin
            left_in  = rd_data_ff;
            rd_addr  = rchild_w[AW-1:0];
            state_in = S_DN_CMP;
         end

         S_DN_CMP: begin
            wr_en = 1'b1;
            if (!(pick_key < key_ff)) begin
               state_in = S_DONE;
            end else begin
               // pull the smaller child up, descend one level
               wr_data = pick_key;
               slot_in = pick_idx;
               if (XW'(pick_idx) < XW'(half)) begin
                  rd_addr  = pick_lchild_w[AW-1:0];
                  state_in = S_DN_R;
               end else begin
                  state_in = S_DN_FIN;
               end
            end
         end

         S_DN_FIN: begin
            wr_en    = 1'b1;
            state_in = S_DONE;
         end

         S_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff       <= last_in;
      slot_ff       <= slot_in;
      key_ff        <= key_in;
      left_ff       <= left_in;
      res_key_ff    <= res_key_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_key_ff     <= res_key_ff;
         rsp_status_ff  <= res_status_ff;
         rsp_entries_ff <= ENTRIES_W'(count_ff);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_key_out = rsp_key_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_entries = rsp_entries_ff;

endmodule

[rtl/core/bmhq_checker.sv]
module bmhq_checker
   import bmhq_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [KEY_W-1:0] rsp_key_out,
   input logic [STATUS_W-1:0]     rsp_status,
   input logic [ENTRIES_W-1:0]    rsp_entries
);

   localparam logic [ENTRIES_W-1:0] FULL_ENTRIES = ENTRIES_W'(DEPTH);

   // one request at a time: a taken request blocks the next
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a request is in flight");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_out)
         && $stable(rsp_status) && $stable(rsp_entries))
      else $error("stalled response changed");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_key_out == '0) && (rsp_entries == '0))
      else $error("empty response carries a key or a count");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> (rsp_key_out == '0)
         && (rsp_entries == FULL_ENTRIES))
      else $error("full response with wrong count");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DEPTH > 2047) || (32'(rsp_entries) <= 32'(DEPTH)))
      else $error("count beyond capacity");

endmodule

bind binary_min_heap_queue bmhq_checker #(.DEPTH(DEPTH)) u_bmhq_checker (.*);

[bench/heap_reply_checker.sv]
`timescale 1ns / 1ps

module heap_reply_checker
   import bmhq_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [OP_W-1:0]         req_op,
   input  logic signed [KEY_W-1:0] req_key_in,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic signed [KEY_W-1:0] rsp_key_out,
   input  logic [STATUS_W-1:0]     rsp_status,
   input  logic [ENTRIES_W-1:0]    rsp_entries,
   output int                      fail_count,
   output int                      pending,
   output int                      replies_checked,
   output int                      full_replies,
   output int                      empty_replies
);

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [STATUS_W-1:0]     status;
      logic [ENTRIES_W-1:0]    entries;
   } heap_reply_type;

   // mirror of the heap: only slots below held_keys are meaningful
   logic signed [KEY_W-1:0] heap_keys [DEPTH];
   int unsigned             held_keys = 0;
   heap_reply_type          replies_due [$];
   int                      fails     = 0;
   int                      checked   = 0;
   int                      fulls     = 0;
   int                      empties   = 0;

   // climb from the next free slot while the new key beats its parent
   function automatic void heap_insert(input logic signed [KEY_W-1:0] key);
      int unsigned slot;
      int unsigned up;
      slot = held_keys;
      while (slot > 0) begin
         up = (slot - 1) / 2;
         if (key >= heap_keys[up]) break;
         heap_keys[slot] = heap_keys[up];
         slot = up;
      end
      heap_keys[slot] = key;
      held_keys++;
   endfunction

   // remove the root, then sink the last key along the smaller child
   function automatic logic signed [KEY_W-1:0] heap_take_min();
      logic signed [KEY_W-1:0] root;
      logic signed [KEY_W-1:0] moving;
      int unsigned             remain;
      int unsigned             slot;
      int unsigned             child;
      root   = heap_keys[0];
      remain = held_keys - 1;
      if (remain > 0) begin
         moving = heap_keys[remain];
         slot   = 0;
         while (slot < remain / 2) begin
            child = 2 * slot + 1;
            if (child + 1 < remain && heap_keys[child + 1] < heap_keys[child]) child++;
            if (heap_keys[child] >= moving) break;
            heap_keys[slot] = heap_keys[child];
            slot = child;
         end
         heap_keys[slot] = moving;
      end
      held_keys = remain;
      return root;
   endfunction

   function automatic heap_reply_type heap_apply(input logic [OP_W-1:0] op,
                                                 input logic signed [KEY_W-1:0] key);
      heap_reply_type reply;
      reply.key    = '0;
      reply.status = ST_OK;
      case (op)
         OP_OFFER: begin
            if (held_keys >= DEPTH) reply.status = ST_FULL;
            else heap_insert(key);
         end
         OP_POLL: begin
            if (held_keys == 0) reply.status = ST_EMPTY;
            else reply.key = heap_take_min();
         end
         OP_PEEK: begin
            if (held_keys == 0) reply.status = ST_EMPTY;
            else reply.key = heap_keys[0];
         end
         default: begin
         end
      endcase
      reply.entries = held_keys[ENTRIES_W-1:0];
      return reply;
   endfunction

   always @(posedge clock) begin
      heap_reply_type due;
      if (reset) begin
         replies_due.delete();
         held_keys = 0;
      end else begin
         // retire the response first: it always belongs to an older request
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               $error("response with no request outstanding: key_out %0d status %0d",
                      rsp_key_out, rsp_status);
               fails++;
            end else begin
               due = replies_due.pop_front();
               checked++;
               if (rsp_key_out !== due.key) begin
                  $error("key_out: expected %0d, got %0d", due.key, rsp_key_out);
                  fails++;
               end
               if (rsp_status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_status);
                  fails++;
               end
               if (rsp_entries !== due.entries) begin
                  $error("entries: expected %0d, got %0d", due.entries, rsp_entries);
                  fails++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            due = heap_apply(req_op, req_key_in);
            if (due.status == ST_FULL) fulls++;
            if (due.status == ST_EMPTY) empties++;
            replies_due.push_back(due);
         end
      end
      fail_count      <= fails;
      pending         <= replies_due.size();
      replies_checked <= checked;
      full_replies    <= fulls;
      empty_replies   <= empties;
   end

endmodule

[bench/binary_min_heap_queue_tb.sv]
`timescale 1ns / 1ps

module binary_min_heap_queue_tb;
   import bmhq_pkg::*;

   localparam int DEPTH       = 1024;
   localparam int LONG_HOLD   = 400;      // receiver hold-off while the heap fills
   localparam int DRAIN_WAIT  = 40;
   localparam int CYCLE_LIMIT = 800000;

   // op code 3 is not decoded by the block: it only reports the count
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [OP_W-1:0]         req_op;
   logic signed [KEY_W-1:0] req_key_in;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [KEY_W-1:0] rsp_key_out;
   logic [STATUS_W-1:0]     rsp_status;
   logic [ENTRIES_W-1:0]    rsp_entries;

   int fail_count;
   int pending;
   int replies_checked;
   int full_replies;
   int empty_replies;

   int   requests_sent;
   int   cycle_count = 0;
   logic sender_burst;
   logic receiver_burst;
   logic fill_started;
   logic long_hold_done;

   binary_min_heap_queue #(
      .DEPTH (DEPTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_key_in  (req_key_in),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_key_out (rsp_key_out),
      .rsp_status  (rsp_status),
      .rsp_entries (rsp_entries)
   );

   heap_reply_checker #(
      .DEPTH (DEPTH)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_key_in      (req_key_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_out     (rsp_key_out),
      .rsp_status      (rsp_status),
      .rsp_entries     (rsp_entries),
      .fail_count      (fail_count),
      .pending         (pending),
      .replies_checked (replies_checked),
      .full_replies    (full_replies),
      .empty_replies   (empty_replies)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Bound the run: a hung handshake ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Mix extremes, a narrow band that produces many equal keys, and
   // full-width random patterns so every key bit toggles.
   function automatic logic signed [KEY_W-1:0] draw_key();
      logic signed [KEY_W-1:0] near_zero;
      near_zero = $signed($urandom_range(0, 8)) - 4;
      case ($urandom_range(0, 7))
         0: begin
            return 32'sh7FFF_FFFF;
         end
         1: begin
            return 32'sh8000_0000;
         end
         2, 3: begin
            return near_zero;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // Pick an op by percentage weights; what is left over becomes the unused code.
   function automatic logic [OP_W-1:0] pick_op(input int offer_pct, input int poll_pct,
                                                input int peek_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < offer_pct) return OP_OFFER;
      if (roll < offer_pct + poll_pct) return OP_POLL;
      if (roll < offer_pct + poll_pct + peek_pct) return OP_PEEK;
      return OP_NONE;
   endfunction

   // Offer one request after a random gap and hold it until the block takes it.
   // Valid stays high from one request to the next when the gap is zero, so it
   // is never lowered and raised within the same step.
   task automatic send_request(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key);
      int gap;
      if ($urandom_range(0, 63) == 0) sender_burst = ~sender_burst;
      gap = sender_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_op     <= op;
      req_key_in <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   // Receiver: stall each response for a random count of cycles, with burst
   // stretches of no stall. Once the fill phase starts, hold off for a long
   // stretch so the response register fills and the block stalls its input.
   initial begin
      int gap;
      rsp_stall      <= 1'b0;
      receiver_burst  = 1'b0;
      long_hold_done  = 1'b0;
      forever begin
         if (fill_started && !long_hold_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_done = 1'b1;
         end else begin
            if ($urandom_range(0, 63) == 0) receiver_burst = ~receiver_burst;
            gap = receiver_burst ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_op        <= OP_OFFER;
      req_key_in    <= '0;
      fill_started  <= 1'b0;
      sender_burst   = 1'b0;
      requests_sent  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Empty heap: every read reports empty, the unused code reports zero.
      send_request(OP_PEEK, 32'sd17);
      send_request(OP_POLL, -32'sd1);
      send_request(OP_NONE, 32'sh7FFF_FFFF);
      // Extremes: the most negative key must climb to the root.
      send_request(OP_OFFER, 32'sh7FFF_FFFF);
      send_request(OP_OFFER, 32'sh8000_0000);
      send_request(OP_PEEK, 32'sd0);
      // Equal keys exercise the tie rules on the way up and down.
      send_request(OP_OFFER, 32'sd0);
      send_request(OP_OFFER, -32'sd1);
      send_request(OP_OFFER, 32'sd5);
      send_request(OP_OFFER, 32'sd5);
      send_request(OP_OFFER, 32'sd5);
      send_request(OP_OFFER, 32'sh7FFF_FFFF);
      send_request(OP_NONE, 32'sh8000_0000);
      send_request(OP_PEEK, -32'sd1);
      // Drain to empty in sorted order, then one poll past empty.
      repeat (9) send_request(OP_POLL, draw_key());
      send_request(OP_PEEK, draw_key());

      // Random mix around a shallow heap.
      repeat (200) send_request(pick_op(45, 35, 15), draw_key());

      // Fill past capacity: the trailing offers come back full and the
      // receiver's long hold-off backs the block up meanwhile.
      fill_started <= 1'b1;
      repeat (DEPTH + 6) send_request(OP_OFFER, draw_key());

      // Poll-heavy traffic on a deep heap: long sift-down walks.
      repeat (300) send_request(pick_op(12, 75, 8), draw_key());

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d requests over %0d cycles; %0d responses checked.",
               requests_sent, cycle_count, replies_checked);
      $display("Heap reached capacity with %0d rejected offers; %0d reads on an empty heap.",
               full_replies, empty_replies);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
